// ===== rtl/sli_pkg.sv =====
package sli_pkg;

	// table geometry
	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = $clog2(CAPACITY);

	// request and result field widths
	localparam int VAL_W  = 32;
	localparam int RANK_W = 8;
	localparam int STAT_W = 2;
	localparam int CMP_W  = (RANK_W > CNT_W) ? RANK_W : CNT_W;

	// operation codes
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	// status codes
	localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RESP
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic load_req;
		logic exec;
	} cmd_t;

endpackage

// ===== rtl/sli_ctrl.sv =====
module sli_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	output sli_pkg::cmd_t cmd
);
	import sli_pkg::*;

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (!out_stall) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		in_stall     = 1'b1;
		out_valid    = 1'b0;
		cmd.load_req = 1'b0;
		cmd.exec     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall     = 1'b0;
				cmd.load_req = in_valid;
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
			end
			ST_RESP: begin
				out_valid = 1'b1;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

// ===== rtl/sli_datapath.sv =====
module sli_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  sli_pkg::cmd_t                       cmd,
	input  logic                                operation,
	input  logic signed [sli_pkg::VAL_W-1:0]    value,
	input  logic        [sli_pkg::RANK_W-1:0]   rank,
	output logic        [sli_pkg::STAT_W-1:0]   status,
	output logic        [sli_pkg::CNT_W-1:0]    count
);
	import sli_pkg::*;

	logic                    op_q;
	logic signed [VAL_W-1:0] value_q;
	logic [RANK_W-1:0]       rank_q;
	logic [CNT_W-1:0]        count_q;
	logic [STAT_W-1:0]       status_q;
	logic signed [VAL_W-1:0] tbl_q [CAPACITY];

	logic [CAPACITY-1:0]     lt;
	logic signed [VAL_W-1:0] ins_d [CAPACITY];
	logic signed [VAL_W-1:0] rem_d [CAPACITY];
	logic                    full;
	logic                    out_of_range;

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			op_q    <= operation;
			value_q <= value;
			rank_q  <= rank;
		end
	end

	// per-entry compare: valid entries smaller than the new value form a prefix
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			lt[i] = (CNT_W'(i) < count_q) && (tbl_q[i] < value_q);
		end
	end

	// shifted tables for insert and remove
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			if (lt[i]) begin
				ins_d[i] = tbl_q[i];
			end else if (i == 0) begin
				ins_d[i] = value_q;
			end else if (lt[(i > 0) ? i - 1 : 0]) begin
				ins_d[i] = value_q;
			end else begin
				ins_d[i] = tbl_q[(i > 0) ? i - 1 : 0];
			end
			if (i < CAPACITY - 1 && RANK_W'(i) >= rank_q) begin
				rem_d[i] = tbl_q[(i < CAPACITY - 1) ? i + 1 : i];
			end else begin
				rem_d[i] = tbl_q[i];
			end
		end
	end

	assign full         = (count_q == CNT_W'(CAPACITY));
	assign out_of_range = (CMP_W'(rank_q) >= CMP_W'(count_q));

	// table update
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (op_q == OP_INSERT && !full) begin
				for (int i = 0; i < CAPACITY; i++) tbl_q[i] <= ins_d[i];
			end else if (op_q == OP_REMOVE && !out_of_range) begin
				for (int i = 0; i < CAPACITY; i++) tbl_q[i] <= rem_d[i];
			end
		end
	end

	// count and status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			status_q <= STAT_DONE;
		end else if (cmd.exec) begin
			if (op_q == OP_INSERT) begin
				if (full) begin
					status_q <= STAT_FULL;
				end else begin
					status_q <= STAT_DONE;
					count_q  <= count_q + CNT_W'(1);
				end
			end else begin
				if (out_of_range) begin
					status_q <= STAT_RANGE;
				end else begin
					status_q <= STAT_DONE;
					count_q  <= count_q - CNT_W'(1);
				end
			end
		end
	end

	assign status = status_q;
	assign count  = count_q;

endmodule

// ===== rtl/sorted_list_insert_remove.sv =====
// Sorted store of signed 32-bit values with insert and remove by rank.
// Input channel: in_valid / in_stall carry one request (operation, value,
// rank). Operation insert places value before the first stored value that
// is not smaller; operation remove deletes the entry at rank.
// Output channel: out_valid / out_stall carry one result per request:
// status (done, rank out of range, store full) and the entry count after
// the request.
// A request is captured when accepted in idle; the table and count update in
// the execute state and the result is then held. The controller takes one
// request at a time (capture, compare and shift, result hold), and the whole
// table shifts at once in the execute state.
// A stalled result holds status and count and keeps in_stall high until
// it is taken.
// Reset clears the entry count and returns the controller to idle; the
// table itself is not cleared, since only entries below the count are
// ever read.
module sorted_list_insert_remove (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                operation,
	input  logic signed [sli_pkg::VAL_W-1:0]    value,
	input  logic        [sli_pkg::RANK_W-1:0]   rank,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic        [sli_pkg::STAT_W-1:0]   status,
	output logic        [sli_pkg::CNT_W-1:0]    count
);
	import sli_pkg::*;

	cmd_t cmd;

	// control
	sli_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// table and counters
	sli_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.operation (operation),
		.value     (value),
		.rank      (rank),
		.status    (status),
		.count     (count)
	);

	// one request in flight: no request taken while a result is pending
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("request accepted while result pending");

	// count never exceeds capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (count <= CNT_W'(CAPACITY)))
		else $error("count beyond capacity");

	// full status only with a full table
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == STAT_FULL) |-> (count == CNT_W'(CAPACITY)))
		else $error("full status with room left");

	// a taken result is not repeated
	a_no_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall) |=> !out_valid)
		else $error("result repeated");

endmodule

// ===== tb/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sli_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

	typedef struct {
		logic                     op;
		logic signed [VAL_W-1:0]  val;
		logic        [RANK_W-1:0] rnk;
	} request_t;

	typedef struct {
		logic [STAT_W-1:0] status;
		logic [CNT_W-1:0]  count;
	} outcome_t;

	// DUT ports, inputs all known from time zero
	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic                     operation = OP_INSERT;
	logic signed [VAL_W-1:0]  value = '0;
	logic        [RANK_W-1:0] rank = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic        [STAT_W-1:0] status;
	logic        [CNT_W-1:0]  count;

	// stimulus and scoreboard state
	request_t pending_requests[$];
	outcome_t expected_outcomes[$];
	request_t cur_req;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_asked = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int errors = 0;
	int results_seen = 0;

	// sorted store shadow
	logic signed [VAL_W-1:0] shadow_values[CAPACITY];
	int shadow_count = 0;
	int n_inserts = 0;
	int n_full = 0;
	int n_removes = 0;
	int n_range = 0;
	int peak_count = 0;

	sorted_list_insert_remove DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.value     (value),
		.rank      (rank),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.count     (count)
	);

	always #5 clk = ~clk;

	// apply one request to the shadow store, return what the block should answer
	function automatic outcome_t predict_outcome(request_t rq);
		outcome_t o;
		int pos;
		o.status = STAT_DONE;
		if (rq.op == OP_INSERT) begin
			n_inserts++;
			if (shadow_count >= CAPACITY) begin
				o.status = STAT_FULL;
				n_full++;
			end else begin
				// first entry not smaller than the new value
				pos = 0;
				while (pos < shadow_count && shadow_values[pos] < rq.val)
					pos++;
				for (int i = shadow_count; i > pos; i--)
					shadow_values[i] = shadow_values[i-1];
				shadow_values[pos] = rq.val;
				shadow_count++;
			end
		end else begin
			n_removes++;
			if (int'(rq.rnk) >= shadow_count) begin
				o.status = STAT_RANGE;
				n_range++;
			end else begin
				for (int i = rq.rnk; i + 1 < shadow_count; i++)
					shadow_values[i] = shadow_values[i+1];
				shadow_count--;
			end
		end
		if (shadow_count > peak_count)
			peak_count = shadow_count;
		o.count = CNT_W'(shadow_count);
		return o;
	endfunction

	task automatic flag_error(string msg);
		errors++;
		if (errors <= 10)
			$display("[%0t] ERROR: %s", $realtime, msg);
	endtask

	task automatic push_req(logic op, logic signed [VAL_W-1:0] v, int r);
		request_t rq;
		rq.op = op;
		rq.val = v;
		rq.rnk = RANK_W'(r);
		pending_requests.push_back(rq);
	endtask

	// bursts with a drifting insert bias so the store swings between empty and full
	task automatic queue_random_mix(int n);
		int left;
		int burst;
		int bias;
		logic signed [VAL_W-1:0] v;
		int r;
		left = n;
		while (left > 0) begin
			burst = $urandom_range(10, 40);
			if (burst > left)
				burst = left;
			case ($urandom_range(2))
				0: bias = 25;
				1: bias = 50;
				default: bias = 80;
			endcase
			repeat (burst) begin
				case ($urandom_range(3))
					0: v = $signed(VAL_W'($urandom_range(8))) - 4;
					1: case ($urandom_range(3))
						0: v = VAL_MAX;
						1: v = VAL_MIN;
						2: v = '0;
						default: v = -1;
					endcase
					default: v = $urandom;
				endcase
				if ($urandom_range(99) < 85)
					r = $urandom_range(CAPACITY + 1);
				else
					r = $urandom_range(255);
				// noise in the ignored field as well
				if ($urandom_range(99) < bias)
					push_req(OP_INSERT, v, $urandom_range(255));
				else
					push_req(OP_REMOVE, $urandom, r);
			end
			left -= burst;
		end
	endtask

	// request driver: payload holds while stalled, new request only after a take
	always @(posedge clk) begin : drive_requests
		if (arst_n) begin
			if (in_valid && !in_stall)
				expected_outcomes.push_back(predict_outcome(cur_req));
			if (!in_valid || !in_stall) begin
				if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					cur_req = pending_requests.pop_front();
					in_valid <= 1'b1;
					operation <= cur_req.op;
					value <= cur_req.val;
					rank <= cur_req.rnk;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, counted here
	always @(posedge clk) begin : hold_off
		if (hold_seen != hold_asked) begin
			hold_seen <= hold_asked;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// result monitor and receiver stall
	always @(posedge clk) begin : check_results
		outcome_t e;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (expected_outcomes.size() == 0) begin
				flag_error($sformatf("unexpected result status=%0d count=%0d", status, count));
			end else begin
				e = expected_outcomes.pop_front();
				if (status !== e.status)
					flag_error($sformatf("result %0d: status exp %0d got %0d",
						results_seen, e.status, status));
				if (count !== e.count)
					flag_error($sformatf("result %0d: count exp %0d got %0d",
						results_seen, e.count, count));
			end
		end
		out_stall <= (hold_left > 0) || ($urandom_range(99) < recv_stall_pct);
	end

	task automatic drain();
		while (pending_requests.size() != 0 || in_valid || expected_outcomes.size() != 0)
			@(negedge clk);
	endtask

	initial begin : watchdog
		#5ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : sequence_run
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty store, extremes, duplicates, range edges, full store
		push_req(OP_REMOVE, 0, 0);
		push_req(OP_REMOVE, 0, 255);
		push_req(OP_INSERT, VAL_MAX, 0);
		push_req(OP_INSERT, VAL_MIN, 0);
		push_req(OP_INSERT, 0, 0);
		push_req(OP_INSERT, 0, 0);
		push_req(OP_INSERT, -1, 0);
		push_req(OP_INSERT, 1, 0);
		push_req(OP_INSERT, 32'sh5555_5555, 0);
		push_req(OP_INSERT, 32'shAAAA_AAAA, 0);
		push_req(OP_REMOVE, 0, 8);
		push_req(OP_REMOVE, 0, 7);
		push_req(OP_REMOVE, 0, 0);
		for (int i = 0; i < 10; i++)
			push_req(OP_INSERT, (i % 2) ? VAL_MAX : VAL_MIN + i, 0);
		push_req(OP_INSERT, 7, 0);
		push_req(OP_REMOVE, 0, 16);
		push_req(OP_REMOVE, 0, 15);
		drain();

		// no idling, with a long receiver hold-off while requests keep coming
		queue_random_mix(375);
		hold_asked++;
		drain();

		send_idle_pct = 50;
		recv_stall_pct = 0;
		queue_random_mix(375);
		drain();

		send_idle_pct = 0;
		recv_stall_pct = 50;
		queue_random_mix(375);
		drain();

		send_idle_pct = 8;
		recv_stall_pct = 8;
		queue_random_mix(375);
		drain();

		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (10) @(posedge clk);
		if (expected_outcomes.size() != 0)
			flag_error($sformatf("%0d results never arrived", expected_outcomes.size()));

		$display("Ran %0d inserts (%0d refused as full) and %0d removes (%0d out of range),",
			n_inserts, n_full, n_removes, n_range);
		$display("peak occupancy %0d of %0d, %0d results checked, %0d errors.",
			peak_count, CAPACITY, results_seen, errors);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/sli_pkg.sv
rtl/sli_ctrl.sv
rtl/sli_datapath.sv
rtl/sorted_list_insert_remove.sv
tb/tb.sv
